FILE: hw/rtl/kxd_pkg.sv
// Package for the keystream XOR block with running digest.
// Holds the generator and hash constants and small word helpers.
// No dependencies.
package kxd_pkg;

  // Generator geometry and twist constant.
  localparam logic [9:0]  MT_N       = 10'd624;
  localparam logic [9:0]  MT_M       = 10'd397;
  localparam logic [9:0]  MT_BACK    = 10'd227;
  localparam logic [9:0]  MT_LASTIDX = 10'd623;
  localparam logic [31:0] MT_MATRIX  = 32'h9908B0DF;

  // Hash primes.
  localparam logic [31:0] XP1 = 32'h9E3779B1;
  localparam logic [31:0] XP2 = 32'h85EBCA77;
  localparam logic [31:0] XP3 = 32'hC2B2AE3D;
  localparam logic [31:0] XP4 = 32'h27D4EB2F;
  localparam logic [31:0] XP5 = 32'h165667B1;

  // Seed-zero lane start values and the start value of a four-byte hash.
  localparam logic [31:0] LANE0_INIT = 32'h24234428;
  localparam logic [31:0] LANE1_INIT = 32'h85EBCA77;
  localparam logic [31:0] LANE2_INIT = 32'h00000000;
  localparam logic [31:0] LANE3_INIT = 32'h61C8864F;
  localparam logic [31:0] KEY_INIT   = 32'h165667B5;

  // Mode codes and item kinds.
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_ENCRYPT = 2'd1;
  localparam logic [1:0] MODE_DECRYPT = 2'd2;
  localparam logic       OP_LOAD      = 1'b0;
  localparam logic       OP_DATA      = 1'b1;

  localparam int LENGTH_WIDTH_DEF = 32;

  // Rotate left by a constant amount.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction

  // Generator output tempering.
  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: hw/rtl/keystream_xor_with_digest_top.sv
// Top level of the keystream XOR block with running digest.
// Depends on kxd_pkg for constants and helpers.
//
// Channel | Signals                                             | Direction
// --------+-----------------------------------------------------+----------
// in      | in_valid in_ready op mode word_index word_value     | to block
//         | data_byte last expected_hash                        |
// out     | out_valid out_ready out_byte out_last digest        | from block
//         | digest_match                                        |
//
// One word is worked at a time. A data word is taken, then passes through generator
// memory access (three reads and a write of one lazily twisted word), keystream
// hashing on the shared multiplier and, when hashed, an absorb step, a lane update
// at a full stripe and the digest at the end of a message, and then reaches the
// output register.
// A load word first finishes a twist that was begun, twisting each generator word
// still untwisted, then writes its word. Reset is synchronous and clears control
// and hash state; the generator memory is not cleared. A stalled output holds
// its word while the next input word is taken and worked up to the output.
module keystream_xor_with_digest_top #(
  parameter int LENGTH_WIDTH = kxd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [1:0]  mode,
  input  logic [9:0]  word_index,
  input  logic [31:0] word_value,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [31:0] expected_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] digest,
  output logic        digest_match
);

  // Sequencer codes.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD0  = 5'd1;
  localparam logic [4:0] S_RD1  = 5'd2;
  localparam logic [4:0] S_RD2  = 5'd3;
  localparam logic [4:0] S_CALC = 5'd4;
  localparam logic [4:0] S_LDWR = 5'd5;
  localparam logic [4:0] S_K1   = 5'd6;
  localparam logic [4:0] S_K2   = 5'd7;
  localparam logic [4:0] S_K3   = 5'd8;
  localparam logic [4:0] S_K4   = 5'd9;
  localparam logic [4:0] S_K5   = 5'd10;
  localparam logic [4:0] S_H0   = 5'd11;
  localparam logic [4:0] S_LA   = 5'd12;
  localparam logic [4:0] S_LB   = 5'd13;
  localparam logic [4:0] S_LC   = 5'd14;
  localparam logic [4:0] S_F0   = 5'd15;
  localparam logic [4:0] S_FCHK = 5'd16;
  localparam logic [4:0] S_FW1  = 5'd17;
  localparam logic [4:0] S_FW2  = 5'd18;
  localparam logic [4:0] S_FW3  = 5'd19;
  localparam logic [4:0] S_FB1  = 5'd20;
  localparam logic [4:0] S_FB2  = 5'd21;
  localparam logic [4:0] S_FB3  = 5'd22;
  localparam logic [4:0] S_A1   = 5'd23;
  localparam logic [4:0] S_A2   = 5'd24;
  localparam logic [4:0] S_A3   = 5'd25;
  localparam logic [4:0] S_OUTW = 5'd26;

  logic [4:0] state;

  // Captured input word.
  logic        op_r;
  logic [1:0]  mode_r;
  logic [9:0]  widx_r;
  logic [31:0] wval_r;
  logic [7:0]  din_r;
  logic        last_r;
  logic [31:0] exp_r;

  // Generator memory and its access path.
  logic [31:0] gen_mem [624];
  logic [9:0]  raddr;
  logic [31:0] rdata;
  logic        we;
  logic [9:0]  waddr;
  logic [31:0] wdata;
  logic [9:0]  pos;
  logic [9:0]  pos_p1;
  logic [9:0]  pos_pm;
  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] mix_y;
  logic [31:0] twist_word;
  logic [31:0] nw;

  // Hash state.
  logic [31:0] lane [4];
  logic [7:0]  stripe [16];
  logic [LENGTH_WIDTH-1:0] len;
  logic        lanes_used;
  logic [1:0]  li;
  logic [4:0]  fp;
  logic [31:0] acc;
  logic [7:0]  dout;
  logic [31:0] dg;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [31:0] prod;

  logic        hashing;
  logic [1:0]  wsel;
  logic [31:0] sword;
  logic [7:0]  sbyte;
  logic [31:0] lane_sum;
  logic [4:0]  rem;
  logic [31:0] shifted;

  // Low byte of the avalanche result.
  function automatic logic [7:0] shifted_key(input logic [31:0] p);
    logic [31:0] h;
    h = p ^ (p >> 16);
    return h[7:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign hashing  = (mode_r == kxd_pkg::MODE_ENCRYPT) || (mode_r == kxd_pkg::MODE_DECRYPT);

  // Neighbor addresses of the word being twisted.
  assign pos_p1 = (pos == kxd_pkg::MT_LASTIDX) ? 10'd0 : pos + 10'd1;
  assign pos_pm = (pos < kxd_pkg::MT_BACK) ? pos + kxd_pkg::MT_M : pos - kxd_pkg::MT_BACK;

  // Twist of one word; the third read arrives in the calc cycle.
  assign mix_y      = {w0[31], w1[30:0]};
  assign twist_word = rdata ^ (mix_y >> 1) ^ (mix_y[0] ? kxd_pkg::MT_MATRIX : 32'd0);

  // Memory read address and write port.
  always_comb begin
    raddr = pos;
    case (state)
      S_RD1:   raddr = pos_p1;
      S_RD2:   raddr = pos_pm;
      default: raddr = pos;
    endcase
    we    = 1'b0;
    waddr = pos;
    wdata = twist_word;
    if (state == S_CALC) begin
      we = 1'b1;
    end else if (state == S_LDWR && widx_r < kxd_pkg::MT_N) begin
      we    = 1'b1;
      waddr = widx_r;
      wdata = wval_r;
    end
  end

  // Generator memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      gen_mem[waddr] <= wdata;
    end
    rdata <= gen_mem[raddr];
  end

  // Stripe word and byte selection.
  assign wsel    = (state == S_LA || state == S_LB) ? li : fp[3:2];
  assign sword   = {stripe[{wsel, 2'd3}], stripe[{wsel, 2'd2}],
                    stripe[{wsel, 2'd1}], stripe[{wsel, 2'd0}]};
  assign shifted = sword >> {fp[1:0], 3'b000};
  assign sbyte   = shifted[7:0];
  assign rem     = {1'b0, len[3:0]};

  assign lane_sum = kxd_pkg::rotl32(lane[0], 5'd1) + kxd_pkg::rotl32(lane[1], 5'd7) +
                    kxd_pkg::rotl32(lane[2], 5'd12) + kxd_pkg::rotl32(lane[3], 5'd18);

  // Multiplier operands for each step.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_K1: begin
        mul_a = kxd_pkg::mt_temper(nw);
        mul_b = kxd_pkg::XP3;
      end
      S_K2: begin
        mul_a = kxd_pkg::rotl32(kxd_pkg::KEY_INIT + prod, 5'd17);
        mul_b = kxd_pkg::XP4;
      end
      S_K3: begin
        mul_a = prod ^ (prod >> 15);
        mul_b = kxd_pkg::XP2;
      end
      S_K4, S_A2: begin
        mul_a = prod ^ (prod >> 13);
        mul_b = kxd_pkg::XP3;
      end
      S_LA: begin
        mul_a = sword;
        mul_b = kxd_pkg::XP2;
      end
      S_LB: begin
        mul_a = kxd_pkg::rotl32(lane[li] + prod, 5'd13);
        mul_b = kxd_pkg::XP1;
      end
      S_FW1: begin
        mul_a = sword;
        mul_b = kxd_pkg::XP3;
      end
      S_FW2: begin
        mul_a = kxd_pkg::rotl32(acc + prod, 5'd17);
        mul_b = kxd_pkg::XP4;
      end
      S_FB1: begin
        mul_a = {24'd0, sbyte};
        mul_b = kxd_pkg::XP5;
      end
      S_FB2: begin
        mul_a = kxd_pkg::rotl32(acc + prod, 5'd11);
        mul_b = kxd_pkg::XP1;
      end
      S_A1: begin
        mul_a = acc ^ (acc >> 15);
        mul_b = kxd_pkg::XP2;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[31:0];
  end

  // Sequencer and hash state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= kxd_pkg::MT_N;
      lane[0]    <= kxd_pkg::LANE0_INIT;
      lane[1]    <= kxd_pkg::LANE1_INIT;
      lane[2]    <= kxd_pkg::LANE2_INIT;
      lane[3]    <= kxd_pkg::LANE3_INIT;
      for (int i = 0; i < 16; i++) begin
        stripe[i] <= 8'd0;
      end
      len        <= '0;
      lanes_used <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op;
            mode_r <= mode;
            widx_r <= word_index;
            wval_r <= word_value;
            din_r  <= data_byte;
            last_r <= last;
            exp_r  <= expected_hash;
            if (op == kxd_pkg::OP_DATA) begin
              if (pos == kxd_pkg::MT_N) begin
                pos <= 10'd0;
              end
              state <= S_RD0;
            end else begin
              state <= (pos < kxd_pkg::MT_N) ? S_RD0 : S_LDWR;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          w0    <= rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          w1    <= rdata;
          state <= S_CALC;
        end
        // Write back the twisted word; a load finishes the twist first.
        S_CALC: begin
          nw  <= twist_word;
          pos <= pos + 10'd1;
          if (op_r == kxd_pkg::OP_DATA) begin
            state <= S_K1;
          end else begin
            state <= (pos_p1 == 10'd0) ? S_LDWR : S_RD0;
          end
        end
        S_LDWR: begin
          pos   <= kxd_pkg::MT_N;
          state <= S_IDLE;
        end
        S_K1: state <= S_K2;
        S_K2: state <= S_K3;
        S_K3: state <= S_K4;
        S_K4: state <= S_K5;
        // Keystream byte ready.
        S_K5: begin
          dout <= din_r ^ shifted_key(prod);
          if (hashing) begin
            state <= S_H0;
          end else begin
            state <= S_OUTW;
          end
        end
        // Absorb one byte into the stripe.
        S_H0: begin
          stripe[len[3:0]] <= (mode_r == kxd_pkg::MODE_ENCRYPT) ? din_r : dout;
          len              <= len + 1'b1;
          li               <= 2'd0;
          if (len[3:0] == 4'hF) begin
            state <= S_LA;
          end else begin
            state <= last_r ? S_F0 : S_OUTW;
          end
        end
        S_LA: state <= S_LB;
        S_LB: state <= S_LC;
        S_LC: begin
          lane[li] <= prod;
          li       <= li + 2'd1;
          if (li == 2'd3) begin
            lanes_used <= 1'b1;
            state      <= last_r ? S_F0 : S_OUTW;
          end else begin
            state <= S_LA;
          end
        end
        // Digest: start value, then words, bytes and the final mix.
        S_F0: begin
          acc   <= (lanes_used ? lane_sum : kxd_pkg::XP5) + 32'(len);
          fp    <= 5'd0;
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (fp + 5'd4 <= rem) begin
            state <= S_FW1;
          end else if (fp < rem) begin
            state <= S_FB1;
          end else begin
            state <= S_A1;
          end
        end
        S_FW1: state <= S_FW2;
        S_FW2: state <= S_FW3;
        S_FW3: begin
          acc   <= prod;
          fp    <= fp + 5'd4;
          state <= S_FCHK;
        end
        S_FB1: state <= S_FB2;
        S_FB2: state <= S_FB3;
        S_FB3: begin
          acc   <= prod;
          fp    <= fp + 5'd1;
          state <= S_FCHK;
        end
        S_A1: state <= S_A2;
        S_A2: state <= S_A3;
        S_A3: begin
          dg    <= prod ^ (prod >> 16);
          state <= S_OUTW;
        end
        // Hand the word to the output register; the message end clears the hash.
        S_OUTW: begin
          if (!out_valid || out_ready) begin
            if (last_r) begin
              lane[0]    <= kxd_pkg::LANE0_INIT;
              lane[1]    <= kxd_pkg::LANE1_INIT;
              lane[2]    <= kxd_pkg::LANE2_INIT;
              lane[3]    <= kxd_pkg::LANE3_INIT;
              for (int i = 0; i < 16; i++) begin
                stripe[i] <= 8'd0;
              end
              len        <= '0;
              lanes_used <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUTW && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUTW && (!out_valid || out_ready)) begin
      out_byte     <= dout;
      out_last     <= last_r;
      digest       <= (last_r && hashing) ? dg : 32'd0;
      digest_match <= last_r && (mode_r == kxd_pkg::MODE_DECRYPT) && (dg == exp_r);
    end
  end

endmodule

FILE: hw/rtl/kxd_checker.sv
// Port checker for the keystream XOR block, bound to the top level.
// Depends only on the top level's ports.
module kxd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [31:0] digest,
  input logic        digest_match
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(digest))
    else $error("output word changed while stalled");

  // Digest and match appear only on the last word of a message.
  a_digest_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> digest == 32'd0 && !digest_match)
    else $error("digest outside message end");

  // One word at a time: an accepted word blocks the input for the next cycle.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind keystream_xor_with_digest_top kxd_checker u_kxd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
  .out_last(out_last), .digest(digest), .digest_match(digest_match)
);

FILE: tb/tb_keystream_xor_with_digest_top.sv
// Self-checking testbench for keystream_xor_with_digest_top.
// It predicts every output word from its own generator and digest model and checks it.
// Depends on kxd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_keystream_xor_with_digest_top;

  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic       op;
    logic [1:0] mode;
    logic [9:0] index;
    logic [31:0] value;
    logic [7:0] data;
    logic       fin;
    logic [31:0] ehash;
  } in_word_t;

  typedef struct {
    logic [7:0]  obyte;
    logic        olast;
    logic [31:0] dig;
    logic        match;
  } out_word_t;

  // Directed rows: the digest columns are typed in only where pinned.
  typedef struct {
    in_word_t  w;
    bit        auto_match;
    bit        pinned;
    out_word_t pin;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = kxd_pkg::OP_LOAD;
  logic [1:0] mode = kxd_pkg::MODE_PLAIN;
  logic [9:0] word_index = '0;
  logic [31:0] word_value = '0;
  logic [7:0] data_byte = '0;
  logic last = 1'b0;
  logic [31:0] expected_hash = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_last;
  logic [31:0] digest;
  logic digest_match;

  keystream_xor_with_digest_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op), .mode(mode),
    .word_index(word_index), .word_value(word_value), .data_byte(data_byte), .last(last),
    .expected_hash(expected_hash), .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_last(out_last), .digest(digest), .digest_match(digest_match)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: generator and streaming digest.
  logic [31:0] gen_words [0:623];
  int          gen_pos;
  logic [31:0] lanes [0:3];
  logic [7:0]  stripe [0:15];
  logic [31:0] hashed_len;
  bit          lanes_full;

  out_word_t expected_q [$];
  int  fail_count = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  cycles = 0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_final(input logic [31:0] h0);
    logic [31:0] h;
    h = h0;
    h = h ^ (h >> 15); h = h * kxd_pkg::XP2;
    h = h ^ (h >> 13); h = h * kxd_pkg::XP3;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [31:0] le_word(input int p);
    return {stripe[p + 3], stripe[p + 2], stripe[p + 1], stripe[p]};
  endfunction

  task automatic clear_digest();
    lanes[0] = kxd_pkg::XP1 + kxd_pkg::XP2;
    lanes[1] = kxd_pkg::XP2;
    lanes[2] = 32'd0;
    lanes[3] = 32'd0 - kxd_pkg::XP1;
    for (int i = 0; i < 16; i++) stripe[i] = 8'd0;
    hashed_len = '0;
    lanes_full = 1'b0;
  endtask

  // In-place twist: later words see already updated ones, as the generator does.
  task automatic twist_generator();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < 624; i++) begin
      y = (gen_words[i] & 32'h80000000) | (gen_words[(i + 1) % 624] & 32'h7FFFFFFF);
      v = gen_words[(i + 397) % 624] ^ (y >> 1);
      if (y[0]) v = v ^ kxd_pkg::MT_MATRIX;
      gen_words[i] = v;
    end
    gen_pos = 0;
  endtask

  task automatic next_key_byte(output logic [7:0] k);
    logic [31:0] y;
    logic [31:0] h;
    if (gen_pos >= 624) twist_generator();
    y = gen_words[gen_pos];
    gen_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    h = kxd_pkg::XP5 + 32'd4;
    h = h + y * kxd_pkg::XP3;
    h = rol(h, 17) * kxd_pkg::XP4;
    h = mix_final(h);
    k = h[7:0];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int fill;
    fill = hashed_len[3:0];
    stripe[fill] = b;
    hashed_len = hashed_len + 1;
    if (fill == 15) begin
      for (int i = 0; i < 4; i++)
        lanes[i] = rol(lanes[i] + le_word(4 * i) * kxd_pkg::XP2, 13) * kxd_pkg::XP1;
      lanes_full = 1'b1;
    end
  endtask

  function automatic logic [31:0] message_digest();
    logic [31:0] h;
    int rem;
    int p;
    rem = hashed_len[3:0];
    p = 0;
    if (lanes_full) h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
    else h = kxd_pkg::XP5;
    h = h + hashed_len;
    while (p + 4 <= rem) begin
      h = h + le_word(p) * kxd_pkg::XP3;
      h = rol(h, 17) * kxd_pkg::XP4;
      p += 4;
    end
    while (p < rem) begin
      h = h + {24'd0, stripe[p]} * kxd_pkg::XP5;
      h = rol(h, 11) * kxd_pkg::XP1;
      p++;
    end
    return mix_final(h);
  endfunction

  // Works out the result of one word; load words give none.
  task automatic predict_word(input in_word_t w, output bit has_out, output out_word_t r);
    logic [7:0] k;
    has_out = 1'b0;
    r = '{8'd0, 1'b0, 32'd0, 1'b0};
    if (w.op == kxd_pkg::OP_LOAD) begin
      if (w.index < kxd_pkg::MT_N) gen_words[w.index] = w.value;
      gen_pos = 624;
    end else begin
      has_out = 1'b1;
      next_key_byte(k);
      r.obyte = w.data ^ k;
      r.olast = w.fin;
      if (w.mode == kxd_pkg::MODE_ENCRYPT) absorb_byte(w.data);
      else if (w.mode == kxd_pkg::MODE_DECRYPT) absorb_byte(r.obyte);
      if (w.fin) begin
        if (w.mode == kxd_pkg::MODE_ENCRYPT || w.mode == kxd_pkg::MODE_DECRYPT) begin
          r.dig = message_digest();
          if (w.mode == kxd_pkg::MODE_DECRYPT) r.match = (r.dig == w.ehash);
        end
        clear_digest();
      end
    end
  endtask

  // Offers one word, with idle gaps by the current phase, and waits for the handshake.
  task automatic send_word(input in_word_t w0, input bit auto_match, input bit pinned,
                           input out_word_t pin);
    in_word_t w;
    bit has_out;
    out_word_t r;
    int gap;
    w = w0;
    predict_word(w, has_out, r);
    // The digest does not depend on the expected hash, so a matching one can be filled in.
    if (auto_match && has_out && w.fin && w.mode == kxd_pkg::MODE_DECRYPT) begin
      w.ehash = r.dig;
      r.match = 1'b1;
    end
    if (pinned) begin
      r.olast = pin.olast;
      r.dig = pin.dig;
      r.match = pin.match;
    end
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= w.op;
    mode <= w.mode;
    word_index <= w.index;
    word_value <= w.value;
    data_byte <= w.data;
    last <= w.fin;
    expected_hash <= w.ehash;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (has_out) expected_q.push_back(r);
    @(negedge clk);
  endtask

  function automatic in_word_t load_w(input logic [9:0] idx, input logic [31:0] val);
    return '{kxd_pkg::OP_LOAD, kxd_pkg::MODE_PLAIN, idx, val, 8'd0, 1'b0, 32'd0};
  endfunction

  function automatic in_word_t data_w(input logic [1:0] md, input logic [7:0] d, input logic f,
                                      input logic [31:0] eh);
    return '{kxd_pkg::OP_DATA, md, 10'd0, 32'd0, d, f, eh};
  endfunction

  function automatic plan_row_t row(input in_word_t w, input bit am, input bit pn,
                                    input logic fl);
    return '{w, am, pn, '{8'd0, fl, 32'd0, 1'b0}};
  endfunction

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Output checker against the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output word, actual byte %h", $time, out_byte);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        check_field("out_byte", {24'd0, e.obyte}, {24'd0, out_byte});
        check_field("out_last", {31'd0, e.olast}, {31'd0, out_last});
        check_field("digest", e.dig, digest);
        check_field("digest_match", {31'd0, e.match}, {31'd0, digest_match});
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    in_word_t w;
    out_word_t none;
    int sent;
    int mlen;
    logic [1:0] mmode;
    bit mixed;
    bit am;

    none = '{8'd0, 1'b0, 32'd0, 1'b0};
    for (int i = 0; i < 624; i++) gen_words[i] = 32'd0;
    gen_pos = 624;
    clear_digest();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole generator before any data word.
    for (int i = 0; i < 624; i++) begin
      w = load_w(i[9:0], (i == 0) ? 32'hFFFFFFFF : (i == 1) ? 32'd0 : $urandom);
      send_word(w, 1'b0, 1'b0, none);
    end

    // Directed part: extremes, every mode, ignored loads, loads inside a message.
    plan.push_back(row(data_w(kxd_pkg::MODE_PLAIN, 8'h00, 1'b0, 32'd0), 1'b0, 1'b1, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_PLAIN, 8'hFF, 1'b1, 32'hFFFFFFFF), 1'b0, 1'b1,
                       1'b1));
    plan.push_back(row(data_w(2'd3, 8'hA5, 1'b1, 32'd0), 1'b0, 1'b1, 1'b1));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h00, 1'b1, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h01, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h80, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'hFF, 1'b1, 32'd0), 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < 4; i++)
      plan.push_back(row(data_w(kxd_pkg::MODE_DECRYPT, 8'(8'h5A + i), i == 3, 32'd0), 1'b1,
                         1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_DECRYPT, 8'hFF, 1'b1, 32'hFFFFFFFF), 1'b0, 1'b0,
                       1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h3C, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_PLAIN, 8'hC3, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_DECRYPT, 8'h7E, 1'b1, 32'd0), 1'b1, 1'b0, 1'b0));
    plan.push_back(row(load_w(10'd1023, 32'hFFFFFFFF), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_PLAIN, 8'h11, 1'b1, 32'd0), 1'b0, 1'b1, 1'b1));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h22, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(load_w(10'd623, 32'hFFFFFFFF), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h33, 1'b1, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_ENCRYPT, 8'h44, 1'b0, 32'd0), 1'b0, 1'b0, 1'b0));
    plan.push_back(row(data_w(kxd_pkg::MODE_PLAIN, 8'h55, 1'b1, 32'd0), 1'b0, 1'b1, 1'b1));
    foreach (plan[i]) send_word(plan[i].w, plan[i].auto_match, plan[i].pinned, plan[i].pin);

    // Random messages in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // Long hold-off while the sender keeps offering words.
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 115) begin
        mlen = ($urandom_range(9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 34);
        mmode = 2'($urandom_range(3));
        mixed = ($urandom_range(9) == 0);
        am = 1'($urandom_range(1));
        for (int b = 0; b < mlen; b++) begin
          if ($urandom_range(99) < 2)
            send_word(load_w(10'($urandom_range(1023)), $urandom), 1'b0, 1'b0, none);
          w = data_w(mixed ? 2'($urandom_range(3)) : mmode, 8'($urandom_range(255)),
                     b == mlen - 1, $urandom);
          send_word(w, am, 1'b0, none);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
